/* rtl/lbo_pkg.sv */
// Shared types and constants for the LED blink / one-shot controller.
package lbo_pkg;

   // Duration or count code that means "forever".
   localparam logic [31:0] INFINITE_CODE_DEFAULT = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        func;
      logic [31:0] interval_ms;
      logic [31:0] flash_count;
   } req_type;

   typedef struct packed {
      logic led_level;
      logic timer_running;
   } rsp_type;

   // Item kinds carried in the func field.
   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_COMMAND = 1'b1;

endpackage

/* rtl/lbo_core.sv */
// LED state and timer update: one item per enabled cycle, result returned as next state.
module lbo_core #(
   parameter logic [31:0] INFINITE_CODE = lbo_pkg::INFINITE_CODE_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  lbo_pkg::req_type item,
   output lbo_pkg::rsp_type result
);
   import lbo_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE          = 2'd0,
      MODE_ONESHOT       = 2'd1,
      MODE_BLINK_FINITE  = 2'd2,
      MODE_BLINK_ENDLESS = 2'd3
   } mode_type;

   logic        led_ff, led_in;
   mode_type    mode_ff, mode_in;
   logic [32:0] toggles_ff, toggles_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [31:0] period_ff, period_in;

   logic [32:0] elapsed_inc;
   logic [32:0] toggles_dec;
   logic [30:0] interval_halved;

   assign elapsed_inc     = {1'b0, elapsed_ff} + 33'd1;
   assign toggles_dec     = toggles_ff - 33'd1;
   assign interval_halved = item.interval_ms[31:1];

   always_comb begin
      led_in     = led_ff;
      mode_in    = mode_ff;
      toggles_in = toggles_ff;
      elapsed_in = elapsed_ff;
      period_in  = period_ff;
      if (item.func == FUNC_COMMAND) begin
         // every command stops the running timer first
         mode_in    = MODE_IDLE;
         toggles_in = '0;
         elapsed_in = '0;
         period_in  = '0;
         if (item.interval_ms == 32'd0) begin
            led_in = 1'b0;
         end else if (item.interval_ms == INFINITE_CODE && item.flash_count == 32'd0) begin
            led_in = 1'b1;
         end else if (item.flash_count == 32'd0) begin
            led_in    = 1'b1;
            mode_in   = MODE_ONESHOT;
            period_in = item.interval_ms;
         end else begin
            if (item.flash_count != INFINITE_CODE) begin
               mode_in    = MODE_BLINK_FINITE;
               toggles_in = {item.flash_count, 1'b0};
            end else begin
               mode_in = MODE_BLINK_ENDLESS;
            end
            period_in = (interval_halved == 31'd0) ? 32'd1 : {1'b0, interval_halved};
         end
      end else if (mode_ff != MODE_IDLE) begin
         if (elapsed_inc >= {1'b0, period_ff}) begin
            elapsed_in = '0;
            if (mode_ff == MODE_ONESHOT) begin
               led_in    = 1'b0;
               mode_in   = MODE_IDLE;
               period_in = '0;
            end else begin
               led_in = ~led_ff;
               if (mode_ff == MODE_BLINK_FINITE) begin
                  if (toggles_dec == 33'd0) begin
                     led_in     = 1'b0;
                     mode_in    = MODE_IDLE;
                     toggles_in = '0;
                     period_in  = '0;
                  end else begin
                     toggles_in = toggles_dec;
                  end
               end
            end
         end else begin
            elapsed_in = elapsed_inc[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff     <= 1'b0;
         mode_ff    <= MODE_IDLE;
         toggles_ff <= '0;
         elapsed_ff <= '0;
         period_ff  <= '0;
      end else if (step_en) begin
         led_ff     <= led_in;
         mode_ff    <= mode_in;
         toggles_ff <= toggles_in;
         elapsed_ff <= elapsed_in;
         period_ff  <= period_in;
      end
   end

   assign result.led_level     = led_in;
   assign result.timer_running = (mode_in != MODE_IDLE);

`ifndef SYNTHESIS
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> toggles_ff == 33'd0 && elapsed_ff == 32'd0 && period_ff == 32'd0)
      else $error("idle with timer state left over");
   a_finite_left: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_BLINK_FINITE |-> toggles_ff != 33'd0)
      else $error("finite blink with no toggles left");
   a_period_set: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_IDLE |-> period_ff != 32'd0)
      else $error("running timer with zero period");
   a_elapsed_below: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_IDLE |-> elapsed_ff < period_ff)
      else $error("elapsed count passed the period");
`endif

endmodule

/* rtl/led_blink_oneshot_controller.sv */
// Top level of the LED blink / one-shot controller: transfer handshakes around the core.
// Each request is a one-millisecond tick or a control command; each produces exactly one
// response carrying the LED level and whether a one-shot or blink timer is running after
// that item. A command stops the timer and selects off (interval 0), steady on (infinite
// interval, count 0), one-shot (lit for interval ms) or blink (toggle every interval/2 ms,
// at least 1; 2*count toggles then off, or endless for an infinite count). Throughput is one
// transfer per cycle while the response side does not stall: the request lands in the request
// register on the transfer edge, and once the response register can take a result the state
// update lands in the core registers and the response register together. A stalled
// response stalls the request side only once the request register is also full.
module led_blink_oneshot_controller #(
   parameter logic [31:0] INFINITE_CODE = lbo_pkg::INFINITE_CODE_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lbo_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lbo_pkg::rsp_type rsp_data
);
   import lbo_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type core_result;

   logic advance;   // response register can take a new result this cycle
   logic step_en;   // held request is processed this cycle
   logic req_take;  // request transfer

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // request register empties when its item moves on, refills on a transfer
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   // response stays while stalled, replaced when a new result arrives
   assign rsp_valid_in = step_en || (rsp_valid_ff && rsp_stall);

   lbo_core #(
      .INFINITE_CODE(INFINITE_CODE)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step_en(step_en),
      .item   (in_data_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (step_en) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("held request lost while response stalled");
   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $past(step_en) && !$past(reset) |-> rsp_valid_ff)
      else $error("processed request produced no response");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !$past(rsp_valid_ff) && !$past(step_en) && !$past(reset) |-> !rsp_valid_ff)
      else $error("response appeared without a request");
`endif

endmodule

/* tb/led_level_checker.sv */
`timescale 1ns / 1ps
// Checker for the LED controller: predicts each response and compares it with the DUT output.
module led_level_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  lbo_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  lbo_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               outstanding
);
   import lbo_pkg::*;

   localparam logic [31:0] INFINITE = INFINITE_CODE_DEFAULT;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_ONESHOT,
      MODE_BLINK_FINITE,
      MODE_BLINK_ENDLESS
   } blink_mode_type;

   logic           led_on;
   blink_mode_type mode;
   logic [32:0]    toggles_left;
   logic [31:0]    elapsed_ms;
   logic [31:0]    period_ms;
   rsp_type        expected_led_q[$];
   rsp_type        oldest;
   int             error_total = 0;

   function automatic void clear_timer();
      mode         = MODE_IDLE;
      toggles_left = '0;
      elapsed_ms   = '0;
      period_ms    = '0;
   endfunction

   // Updates the LED state for one transfer and returns the response it should produce.
   function automatic rsp_type apply_led_item(req_type item);
      logic [32:0] next_ms;
      logic [31:0] half_ms;
      rsp_type     outcome;
      if (item.func == FUNC_COMMAND) begin
         clear_timer();
         if (item.interval_ms == '0) begin
            led_on = 1'b0;
         end else if (item.interval_ms == INFINITE && item.flash_count == '0) begin
            led_on = 1'b1;
         end else if (item.flash_count == '0) begin
            led_on    = 1'b1;
            mode      = MODE_ONESHOT;
            period_ms = item.interval_ms;
         end else begin
            // blink keeps the present LED level
            if (item.flash_count != INFINITE) begin
               mode         = MODE_BLINK_FINITE;
               toggles_left = {item.flash_count, 1'b0};
            end else begin
               mode = MODE_BLINK_ENDLESS;
            end
            half_ms   = item.interval_ms >> 1;
            period_ms = (half_ms == '0) ? 32'd1 : half_ms;
         end
      end else if (mode != MODE_IDLE) begin
         next_ms = {1'b0, elapsed_ms} + 33'd1;
         if (next_ms >= {1'b0, period_ms}) begin
            elapsed_ms = '0;
            if (mode == MODE_ONESHOT) begin
               led_on = 1'b0;
               clear_timer();
            end else begin
               led_on = ~led_on;
               if (mode == MODE_BLINK_FINITE) begin
                  toggles_left = toggles_left - 33'd1;
                  if (toggles_left == '0) begin
                     led_on = 1'b0;
                     clear_timer();
                  end
               end
            end
         end else begin
            elapsed_ms = next_ms[31:0];
         end
      end
      outcome.led_level     = led_on;
      outcome.timer_running = (mode != MODE_IDLE);
      return outcome;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         led_on = 1'b0;
         clear_timer();
         expected_led_q.delete();
      end else begin
         // compare before predicting, so a response never matches a same-edge request
         if (rsp_valid && !rsp_stall) begin
            if (expected_led_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual led=%0b run=%0b",
                        $time, rsp_data.led_level, rsp_data.timer_running);
               error_total++;
            end else begin
               oldest = expected_led_q.pop_front();
               if (rsp_data.led_level !== oldest.led_level) begin
                  $display("%0t: led_level mismatch, expected %0b, actual %0b",
                           $time, oldest.led_level, rsp_data.led_level);
                  error_total++;
               end
               if (rsp_data.timer_running !== oldest.timer_running) begin
                  $display("%0t: timer_running mismatch, expected %0b, actual %0b",
                           $time, oldest.timer_running, rsp_data.timer_running);
                  error_total++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_led_q.push_back(apply_led_item(req_data));
      end
      mismatch_count <= error_total;
      outstanding    <= expected_led_q.size();
   end

endmodule

/* tb/led_blink_oneshot_controller_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the LED blink / one-shot controller: stimulus, flow pacing and verdict.
module led_blink_oneshot_controller_tb;
   import lbo_pkg::*;

   localparam logic [31:0] INFINITE     = INFINITE_CODE_DEFAULT;
   localparam int          ITEM_TARGET  = 1900;
   // Watchdog bound on the run, far above the worst case with stalls and gaps.
   localparam int          CYCLE_LIMIT  = 400000;
   // Covers the request register plus the response register, with margin.
   localparam int          DRAIN_CYCLES = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int mismatch_count;
   int outstanding;
   int items_sent  = 0;
   int burst_left  = 0;
   int cycle_count = 0;
   bit paused_once = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   led_blink_oneshot_controller #(
      .INFINITE_CODE(INFINITE)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Watches both channels, predicts every response and counts mismatches.
   led_level_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Offers one transfer and holds it until accepted. Valid is only dropped when the
   // current burst runs out, so back-to-back transfers never toggle valid within a step.
   task automatic offer_item(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         // mostly short bursts, now and then a long unbroken stretch
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
      end
   endtask

   task automatic send_command(input logic [31:0] interval, input logic [31:0] count);
      offer_item(req_type'{FUNC_COMMAND, interval, count});
   endtask

   // Ticks ignore interval and count, so those carry random bits.
   task automatic send_ticks(input int n);
      repeat (n) offer_item(req_type'{FUNC_TICK, $urandom(), $urandom()});
   endtask

   // Stops offering and waits until every predicted response has come back.
   // The first edge lets the checker's count catch up with the last transfer.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Random command mix: mostly short timers that actually fire, plus full-range
   // fields so every bit of interval and count toggles.
   task automatic send_random_command();
      int          pick;
      logic [31:0] interval;
      logic [31:0] count;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         interval = '0;                        // off
         count    = $urandom();
      end else if (pick == 1) begin
         interval = INFINITE;                  // steady on
         count    = '0;
      end else if (pick <= 4) begin
         interval = $urandom_range(1, 12);     // one-shot
         count    = '0;
      end else if (pick <= 12) begin
         interval = $urandom_range(1, 12);     // finite blink
         count    = $urandom_range(1, 4);
      end else if (pick <= 15) begin
         interval = $urandom_range(1, 12);     // endless blink
         count    = INFINITE;
      end else if (pick == 16) begin
         interval = $urandom();
         count    = $urandom();
      end else if (pick == 17) begin
         interval = $urandom();
         count    = ($urandom_range(0, 1) == 0) ? 32'd0 : INFINITE;
      end else if (pick == 18) begin
         interval = $urandom_range(1, 12);     // huge flash count
         count    = $urandom();
      end else begin
         interval = INFINITE;
         count    = $urandom_range(0, 1) == 0 ? INFINITE : 32'($urandom_range(1, 3));
      end
      send_command(interval, count);
   endtask

   // Receiver: segments of no stall, random stall, periodic stall and long hold.
   // The fifth segment is always a random-stall segment.
   initial begin
      int segment;
      int pattern;
      int period;
      segment = 0;
      while (reset) @(posedge clock);
      forever begin
         segment++;
         pattern = (segment == 5) ? 3 : $urandom_range(0, 7);
         if (pattern <= 1) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(10, 60)) @(posedge clock);
         end else if (pattern <= 4) begin
            repeat ($urandom_range(10, 60)) begin
               rsp_stall <= ($urandom_range(0, 9) < 3);
               @(posedge clock);
            end
         end else if (pattern <= 6) begin
            period = $urandom_range(2, 5);
            for (int c = 0; c < 40; c++) begin
               rsp_stall <= (c % period == 0);
               @(posedge clock);
            end
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(40, 100)) @(posedge clock);
         end
      end
   end

   // Main stimulus: reset, directed cases, then random command/tick sequences.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // tick while idle, with every field bit set
      offer_item(req_type'{FUNC_TICK, INFINITE, INFINITE});
      send_command(32'd0, INFINITE);           // off
      send_command(INFINITE, 32'd0);           // steady on
      send_ticks(1);
      send_command(32'd1, 32'd0);              // one-shot, fires on first tick
      send_ticks(1);
      send_command(32'd3, 32'd0);              // one-shot of 3 ms
      send_ticks(3);
      send_command(32'd1, 32'd1);              // blink from off, period floor of 1 ms
      send_ticks(2);
      send_command(INFINITE, 32'd0);           // on again
      send_command(32'd3, 32'd1);              // blink starting from lit
      send_ticks(2);
      send_command(32'd2, INFINITE);           // endless blink
      send_ticks(2);
      send_command(INFINITE, INFINITE);        // endless blink, very long period
      send_ticks(1);
      send_command(32'd2, 32'hFFFF_FFFE);      // flash count whose double needs 33 bits
      send_ticks(1);
      send_command(32'd5, 32'h8000_0000);
      send_ticks(1);
      send_command(32'd0, 32'd0);              // off while a timer runs
      wait_for_drain();

      while (items_sent < ITEM_TARGET) begin
         send_random_command();
         send_ticks($urandom_range(0, 40));
         // once mid-run, let the block empty out completely
         if (!paused_once && items_sent >= ITEM_TARGET / 2) begin
            paused_once = 1'b1;
            wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
